// ===== design/abscb_pkg.sv =====
// Shared types, codes, constants and CRC helpers of the A/B slot control block updater.
`default_nettype none

package abscb_pkg;

  localparam int BLOCK_BYTES = 32;
  localparam int ADDR_W = $clog2(BLOCK_BYTES);
  localparam int CRC_LEN = 28;
  localparam logic [ADDR_W-1:0] OFF_A = ADDR_W'(12);
  localparam logic [ADDR_W-1:0] OFF_B = ADDR_W'(14);
  localparam logic [ADDR_W-1:0] OFF_CRC = ADDR_W'(28);

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  localparam logic [7:0] MAGIC_0 = 8'h42;
  localparam logic [7:0] MAGIC_1 = 8'h43;
  localparam logic [7:0] MAGIC_2 = 8'h41;
  localparam logic [7:0] MAGIC_3 = 8'h42;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_B = 8'h62;
  localparam logic [7:0] BLOCK_VERSION = 8'h01;
  localparam logic [2:0] SLOT_COUNT = 3'd2;
  localparam logic [3:0] PRIO_TOP = 4'hf;
  localparam logic [3:0] PRIO_NEXT = 4'he;

  localparam logic [2:0] ACT_LOAD = 3'd0;
  localparam logic [2:0] ACT_STATUS = 3'd1;
  localparam logic [2:0] ACT_PREFER = 3'd2;
  localparam logic [2:0] ACT_ARM = 3'd3;
  localparam logic [2:0] ACT_MARK = 3'd4;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_MAGIC = 4'd1;
  localparam logic [3:0] ST_SUFFIX = 4'd2;
  localparam logic [3:0] ST_VERSION = 4'd3;
  localparam logic [3:0] ST_COUNT = 4'd4;
  localparam logic [3:0] ST_CRC = 4'd5;
  localparam logic [3:0] ST_NOT_BOOTABLE = 4'd6;
  localparam logic [3:0] ST_ARM_ACTIVE = 4'd7;
  localparam logic [3:0] ST_OTHER_UNPROVEN = 4'd8;
  localparam logic [3:0] ST_MARK_INACTIVE = 4'd9;
  localparam logic [3:0] ST_NO_BOOTABLE = 4'd10;
  localparam logic [3:0] ST_INCOMPLETE = 4'd11;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] byte_index;
    logic [7:0] data_byte;
    logic       slot_select;
    logic [2:0] arm_tries;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  slot_a_meta;
    logic [7:0]  slot_b_meta;
    logic [31:0] block_crc;
    logic        selected_slot;
    logic        intent_slot;
    logic        committed;
  } resp_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] new_a;
    logic [7:0] new_b;
  } guard_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINAL,
    S_COMMIT
  } state_t;

  // Folds one byte into a reflected CRC-32, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] d);
    logic [31:0] c;
    c = crc_in ^ {24'd0, d};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic can_boot(input logic [7:0] m);
    return (m[3:0] != 4'd0) && (m[7] || (m[6:4] != 3'd0));
  endfunction

  function automatic logic is_proven(input logic [7:0] m);
    return (m[3:0] != 4'd0) && m[7];
  endfunction

  function automatic logic active_of(input logic [7:0] ma, input logic [7:0] mb);
    return ma[3:0] < mb[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/abscb_store.sv =====
// Block byte store: 32 x 8 synchronous memory, one write and one registered read port.
`default_nettype none

module abscb_store
  import abscb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [BLOCK_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/abscb_guard.sv =====
// Guard rules of prefer, arm and mark successful, and the new slot bytes they give.
`default_nettype none

module abscb_guard
  import abscb_pkg::*;
(
  input  wire logic [2:0] action,
  input  wire logic       slot_select,
  input  wire logic [2:0] arm_tries,
  input  wire logic [7:0] meta_a,
  input  wire logic [7:0] meta_b,
  output guard_res_t      res
);

  logic [7:0] tgt;
  logic [7:0] oth;
  logic [7:0] new_t;
  logic [7:0] new_o;
  logic [3:0] st;
  logic       act;

  always_comb begin
    tgt = slot_select ? meta_b : meta_a;
    oth = slot_select ? meta_a : meta_b;
    act = active_of(meta_a, meta_b);
    new_t = tgt;
    new_o = oth;
    st = ST_OK;
    case (action)
      ACT_PREFER: begin
        if (!can_boot(tgt)) begin
          st = ST_NOT_BOOTABLE;
        end else begin
          new_t = {tgt[7:4], PRIO_TOP};
          new_o = {oth[7:4], PRIO_NEXT};
        end
      end
      ACT_ARM: begin
        if (slot_select == act) begin
          st = ST_ARM_ACTIVE;
        end else if (!is_proven(oth)) begin
          st = ST_OTHER_UNPROVEN;
        end else begin
          new_t = {1'b0, arm_tries, PRIO_TOP};
          new_o = {oth[7:4], PRIO_NEXT};
        end
      end
      ACT_MARK: begin
        // Marking successful clears the tries count.
        if (slot_select != act) begin
          st = ST_MARK_INACTIVE;
        end else begin
          new_t = {1'b1, 3'd0, tgt[3:0]};
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
    res.new_a = slot_select ? new_o : new_t;
    res.new_b = slot_select ? new_t : new_o;
    if (st == ST_OK && !can_boot(res.new_a) && !can_boot(res.new_b)) begin
      st = ST_NO_BOOTABLE;
    end
    res.status = st;
  end

endmodule

`default_nettype wire

// ===== design/ab_slot_control_block_updater_core.sv =====
// Top level of the A/B slot control block updater: sequencer, checks, CRC and result register.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  req_t
//  out      output     out_valid/out_ready  resp_t
//  cfg      input      cfg_valid/cfg_ready  dry_run bit
//
// A load request writes the store directly when it is accepted.
// A command scans the store through its single read port: 34 reads (slot bytes
// first, then bytes 0 to 31), after which the final state forms the result; a
// committing command then holds in_ready low while it writes six bytes (both slot
// bytes and the four CRC bytes). An incomplete block skips the scan and answers
// from the final state.
// Reset clears the loaded-byte mask and dry_run; store contents stay unknown.
// The result register holds while out_ready is low; a finished command waits there for it.
`default_nettype none

module ab_slot_control_block_updater_core
  import abscb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output resp_t     out_data,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data
);

  localparam int STEP_W = $clog2(BLOCK_BYTES + 3);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BLOCK_BYTES + 2);

  state_t state, state_next;

  logic                 dry_run;
  logic [BLOCK_BYTES-1:0] written_mask;
  logic [STEP_W-1:0]    step;
  logic [2:0]           wcnt;
  logic                 incomplete;

  logic [2:0]  cmd_action;
  logic        cmd_slot;
  logic [2:0]  cmd_tries;

  logic [7:0]  meta_a;
  logic [7:0]  meta_b;
  guard_res_t  guard_q;
  guard_res_t  guard_d;
  logic        bad_magic;
  logic        bad_suffix;
  logic        bad_version;
  logic        bad_count;
  logic        intent;
  logic [31:0] crc_old;
  logic [31:0] crc_new;
  logic [31:0] crc_stored;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [7:0]           mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [7:0]           mem_rdata;

  logic              in_fire;
  logic              out_free;
  logic [STEP_W-1:0] pstep;
  logic [ADDR_W-1:0] pidx;
  logic [3:0]        fin_status;
  logic              fin_success;
  logic [7:0]        fin_a;
  logic [7:0]        fin_b;
  logic [31:0]       crc_seal;

  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign crc_seal = ~crc_new;

  abscb_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  abscb_guard u_guard (
    .action      (cmd_action),
    .slot_select (cmd_slot),
    .arm_tries   (cmd_tries),
    .meta_a      (meta_a),
    .meta_b      (mem_rdata),
    .res         (guard_d)
  );

  // Read order: slot a byte, slot b byte, then the whole block in order.
  always_comb begin
    if (step == STEP_W'(0)) begin
      mem_raddr = OFF_A;
    end else if (step == STEP_W'(1)) begin
      mem_raddr = OFF_B;
    end else begin
      mem_raddr = ADDR_W'(step - STEP_W'(2));
    end
    pstep = step - STEP_W'(1);
    pidx = ADDR_W'(step - STEP_W'(3));
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = in_data.byte_index;
    mem_wdata = in_data.data_byte;
    if (state == S_COMMIT) begin
      mem_we = 1'b1;
      case (wcnt)
        3'd0: begin
          mem_waddr = OFF_A;
          mem_wdata = guard_q.new_a;
        end
        3'd1: begin
          mem_waddr = OFF_B;
          mem_wdata = guard_q.new_b;
        end
        3'd2: begin
          mem_waddr = OFF_CRC;
          mem_wdata = crc_seal[7:0];
        end
        3'd3: begin
          mem_waddr = OFF_CRC + ADDR_W'(1);
          mem_wdata = crc_seal[15:8];
        end
        3'd4: begin
          mem_waddr = OFF_CRC + ADDR_W'(2);
          mem_wdata = crc_seal[23:16];
        end
        default: begin
          mem_waddr = OFF_CRC + ADDR_W'(3);
          mem_wdata = crc_seal[31:24];
        end
      endcase
    end else if (in_fire && in_data.action == ACT_LOAD) begin
      mem_we = 1'b1;
    end
  end

  // Result of a finished scan, in the order the checks take precedence.
  always_comb begin
    if (bad_magic) begin
      fin_status = ST_MAGIC;
    end else if (bad_suffix) begin
      fin_status = ST_SUFFIX;
    end else if (bad_version) begin
      fin_status = ST_VERSION;
    end else if (bad_count) begin
      fin_status = ST_COUNT;
    end else if (~crc_old != crc_stored) begin
      fin_status = ST_CRC;
    end else if (cmd_action == ACT_STATUS) begin
      fin_status = ST_OK;
    end else begin
      fin_status = guard_q.status;
    end
    fin_success = (fin_status == ST_OK) && (cmd_action != ACT_STATUS);
    fin_a = fin_success ? guard_q.new_a : meta_a;
    fin_b = fin_success ? guard_q.new_b : meta_b;
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_data.action != ACT_LOAD && in_data.action <= ACT_MARK) begin
          state_next = (&written_mask) ? S_SCAN : S_FINAL;
        end
      end
      S_SCAN: begin
        if (step == STEP_LAST) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          state_next = (!incomplete && fin_success && !dry_run) ? S_COMMIT : S_IDLE;
        end
      end
      S_COMMIT: begin
        if (wcnt == 3'd5) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_run <= 1'b0;
      written_mask <= '0;
      out_valid <= 1'b0;
      step <= '0;
      wcnt <= '0;
      incomplete <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dry_run <= cfg_data;
      end
      if (in_fire && in_data.action == ACT_LOAD) begin
        written_mask[in_data.byte_index] <= 1'b1;
      end
      if (in_fire) begin
        step <= '0;
        incomplete <= !(&written_mask);
      end else if (state == S_SCAN) begin
        step <= step + STEP_W'(1);
      end
      if (state == S_COMMIT) begin
        wcnt <= wcnt + 3'd1;
      end else begin
        wcnt <= '0;
      end
      if (state == S_FINAL && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan datapath: checks and both CRCs advance one byte per cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_action <= in_data.action;
      cmd_slot <= in_data.slot_select;
      cmd_tries <= in_data.arm_tries;
      bad_magic <= 1'b0;
      bad_suffix <= 1'b0;
      bad_version <= 1'b0;
      bad_count <= 1'b0;
      crc_old <= CRC_INIT;
      crc_new <= CRC_INIT;
    end else if (state == S_SCAN && step != STEP_W'(0)) begin
      if (pstep == STEP_W'(0)) begin
        meta_a <= mem_rdata;
      end else if (pstep == STEP_W'(1)) begin
        meta_b <= mem_rdata;
        guard_q <= guard_d;
      end else begin
        case (pidx)
          ADDR_W'(0): bad_suffix <= bad_suffix || (mem_rdata != CHAR_UNDERSCORE);
          ADDR_W'(1): begin
            bad_suffix <= bad_suffix || (mem_rdata != CHAR_A && mem_rdata != CHAR_B);
            intent <= (mem_rdata == CHAR_B);
          end
          ADDR_W'(2), ADDR_W'(3): bad_suffix <= bad_suffix || (mem_rdata != 8'd0);
          ADDR_W'(4): bad_magic <= bad_magic || (mem_rdata != MAGIC_0);
          ADDR_W'(5): bad_magic <= bad_magic || (mem_rdata != MAGIC_1);
          ADDR_W'(6): bad_magic <= bad_magic || (mem_rdata != MAGIC_2);
          ADDR_W'(7): bad_magic <= bad_magic || (mem_rdata != MAGIC_3);
          ADDR_W'(8): bad_version <= (mem_rdata != BLOCK_VERSION);
          ADDR_W'(9): bad_count <= (mem_rdata[2:0] != SLOT_COUNT);
          default: begin
          end
        endcase
        if (pidx < ADDR_W'(CRC_LEN)) begin
          crc_old <= crc_byte(crc_old, mem_rdata);
          if (pidx == OFF_A) begin
            crc_new <= crc_byte(crc_new, guard_q.new_a);
          end else if (pidx == OFF_B) begin
            crc_new <= crc_byte(crc_new, guard_q.new_b);
          end else begin
            crc_new <= crc_byte(crc_new, mem_rdata);
          end
        end else begin
          crc_stored <= {mem_rdata, crc_stored[31:8]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINAL && out_free) begin
      if (incomplete) begin
        out_data <= {ST_INCOMPLETE, 51'd0};
      end else begin
        out_data.status <= fin_status;
        out_data.slot_a_meta <= fin_a;
        out_data.slot_b_meta <= fin_b;
        out_data.block_crc <= fin_success ? crc_seal : crc_stored;
        out_data.selected_slot <= active_of(fin_a, fin_b);
        out_data.intent_slot <= intent;
        out_data.committed <= fin_success && !dry_run;
      end
    end
  end

endmodule

`default_nettype wire
